[hw/rtl/mtb_pkg.sv]
package mtb_pkg;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned LEVEL_W = 9;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IN_W    = 2 * PIX_W + MASK_W;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [CH_W-1:0] FULL_WEIGHT = 8'hff;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONST = 2'd0,
    MODE_FADE  = 2'd1,
    MODE_XFADE = 2'd2
  } blend_mode_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_BLEND_MODE = 1'b0,
    REG_FADE_LEVEL = 1'b1
  } reg_idx_t;

  // one channel: (f*(255-w) + t*w) >> 8, never exceeds 16 bits
  function automatic logic [CH_W-1:0] mix_ch(input logic [CH_W-1:0] f,
                                             input logic [CH_W-1:0] t,
                                             input logic [CH_W-1:0] w);
    logic [2*CH_W-1:0] pf;
    logic [2*CH_W-1:0] pt;
    logic [2*CH_W-1:0] sum;
    pf  = f * (w ^ FULL_WEIGHT);
    pt  = t * w;
    sum = pf + pt;
    return sum[2*CH_W-1:CH_W];
  endfunction

  function automatic logic [CH_W-1:0] weight_of(input logic [MODE_W-1:0] mode,
                                                input logic [LEVEL_W-1:0] lvl,
                                                input logic [MASK_W-1:0] mask);
    logic [LEVEL_W-1:0] d;
    logic               above;
    logic [CH_W-1:0]    w;
    above = lvl > {1'b0, mask};
    d     = lvl - {1'b0, mask};
    case (mode)
      MODE_FADE:  w = above ? FULL_WEIGHT : '0;
      MODE_XFADE: begin
        if (!above) begin
          w = '0;
        end else if (d[LEVEL_W-1]) begin
          w = FULL_WEIGHT;
        end else begin
          w = d[CH_W-1:0];
        end
      end
      default:    w = lvl[CH_W-1:0];
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/masked_transition_blend_top.sv]
// channel  dir  width  contents
// s_*      in   72     tdata: from_pixel[31:0], to_pixel[63:32], mask_level[71:64]
// m_*      out  24     tdata: blended_pixel[23:0]
// apb      in   32     blend_mode @0x0, fade_level @0x4
//
// Two register stages: input register, then weight and blend into the result
// register. One item per cycle sustained while m_tready is high.
// s_tready drops only when both stages are full and m_tready is low.
// rst is synchronous; it clears both valid flags and the two configuration registers.
module masked_transition_blend_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mtb_pkg::IN_W-1:0]      s_tdata,   // from_pixel, to_pixel, mask_level
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mtb_pkg::OUT_W-1:0]     m_tdata,   // blended_pixel
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtb_pkg::APB_AW-1:0]    paddr,
  input  logic [mtb_pkg::APB_DW-1:0]    pwdata,
  output logic [mtb_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic [mtb_pkg::MODE_W-1:0]  blend_mode;
  logic [mtb_pkg::LEVEL_W-1:0] fade_level;
  logic                        cfg_wr;
  mtb_pkg::reg_idx_t           reg_idx;

  logic                        v1;
  logic [mtb_pkg::PIX_W-1:0]   from1;
  logic [mtb_pkg::PIX_W-1:0]   to1;
  logic [mtb_pkg::MASK_W-1:0]  mask1;
  logic                        v2;
  logic [mtb_pkg::OUT_W-1:0]   pix2;
  logic [mtb_pkg::OUT_W-1:0]   pix2_next;
  logic [mtb_pkg::CH_W-1:0]    weight;
  logic                        adv2;
  logic                        adv1;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = mtb_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= '0;
      fade_level <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mtb_pkg::REG_BLEND_MODE: blend_mode <= pwdata[mtb_pkg::MODE_W-1:0];
        mtb_pkg::REG_FADE_LEVEL: fade_level <= pwdata[mtb_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mtb_pkg::REG_BLEND_MODE:
        prdata = {{(mtb_pkg::APB_DW-mtb_pkg::MODE_W){1'b0}}, blend_mode};
      mtb_pkg::REG_FADE_LEVEL:
        prdata = {{(mtb_pkg::APB_DW-mtb_pkg::LEVEL_W){1'b0}}, fade_level};
      default: prdata = '0;
    endcase
  end

  // pipeline flow
  assign adv2     = !v2 || m_tready;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;
  assign m_tvalid = v2;
  assign m_tdata  = pix2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s_tvalid) begin
      from1 <= s_tdata[mtb_pkg::PIX_W-1:0];
      to1   <= s_tdata[2*mtb_pkg::PIX_W-1:mtb_pkg::PIX_W];
      mask1 <= s_tdata[mtb_pkg::IN_W-1:2*mtb_pkg::PIX_W];
    end
  end

  // weight and per-channel blend; alpha byte of both pixels is dropped
  assign weight = mtb_pkg::weight_of(blend_mode, fade_level, mask1);

  assign pix2_next = {mtb_pkg::mix_ch(from1[23:16], to1[23:16], weight),
                      mtb_pkg::mix_ch(from1[15:8],  to1[15:8],  weight),
                      mtb_pkg::mix_ch(from1[7:0],   to1[7:0],   weight)};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      pix2 <= pix2_next;
    end
  end

`ifndef SYNTHESIS
  a_cfg_reset: assert property (@(posedge clk)
    rst |=> (blend_mode == '0 && fade_level == '0))
    else $error("config registers not cleared by reset");

  a_fade_binary: assert property (@(posedge clk) disable iff (rst)
    (blend_mode == mtb_pkg::MODE_FADE) |-> (weight == '0 || weight == mtb_pkg::FULL_WEIGHT))
    else $error("fade mode weight not 0 or full");

  a_xfade_floor: assert property (@(posedge clk) disable iff (rst)
    (blend_mode == mtb_pkg::MODE_XFADE && fade_level <= {1'b0, mask1}) |-> (weight == '0))
    else $error("crossfade weight nonzero below mask");

  a_hold_stage1: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && !m_tready) |=> (v1 && $stable(from1) && $stable(to1) && $stable(mask1)))
    else $error("input stage dropped an item under stall");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted item not held in input stage");
`endif

endmodule
